### sv/frame_rate_decimator_top_macros.svh
// Assertion macros used by the checker file frd_chk.sv.
`ifndef FRAME_RATE_DECIMATOR_TOP_MACROS_SVH
`define FRAME_RATE_DECIMATOR_TOP_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define FRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/frd_pkg.sv
package frd_pkg;

    localparam int TS_W   = 32;
    localparam int RATE_W = 6;
    localparam int TAG_W  = 5;
    localparam int MEAS_W = 16;
    localparam int SKIP_W = 16;
    localparam int ADJ_W  = 2;

    localparam logic [TS_W-1:0]   WINDOW_MS   = 32'd4000;
    localparam logic [ADJ_W-1:0]  MAX_ADJUSTS = 2'd2;
    localparam logic [9:0]        MS_PER_S    = 10'd1000;

    localparam logic [RATE_W-1:0] RESET_REQ   = 6'd30;
    localparam logic [RATE_W-1:0] RESET_TIER  = 6'd30;
    localparam logic [MEAS_W-1:0] RESET_SRC   = 16'd30;
    localparam logic [TAG_W-1:0]  RESET_TAG   = 5'd30;

    // shared divider geometry: 42-bit dividend covers frames * 1000
    localparam int DIV_NW = 42;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = 6;

    localparam logic [DIV_CW-1:0] MEAS_STEPS = 6'd42;
    localparam logic [DIV_CW-1:0] RULE_STEPS = 6'd18;
    localparam logic [DIV_CW-1:0] MOD_STEPS  = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MEAS_DIV,
        ST_RULE,
        ST_RULE_DIV,
        ST_MOD_LOAD,
        ST_MOD_DIV
    } frd_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] steps;
    } frd_div_req_t;

    typedef struct packed {
        logic              keep_frame;
        logic [TAG_W-1:0]  reported_rate;
        logic [MEAS_W-1:0] measured_rate;
    } frd_result_t;

    function automatic logic [TAG_W-1:0] rate_ladder(input logic [MEAS_W-1:0] t);
        logic [TAG_W-1:0] r;
        begin
            if (t > 16'd25)      r = 5'd30;
            else if (t > 16'd20) r = 5'd25;
            else if (t > 16'd15) r = 5'd20;
            else if (t > 16'd10) r = 5'd15;
            else if (t > 16'd5)  r = 5'd10;
            else if (t > 16'd1)  r = 5'd5;
            else                 r = 5'd1;
            return r;
        end
    endfunction

    function automatic logic [RATE_W-1:0] rate_tier(input logic [RATE_W-1:0] req);
        logic [RATE_W-1:0] r;
        begin
            if (req <= 6'd1)       r = 6'd1;
            else if (req <= 6'd5)  r = 6'd5;
            else if (req <= 6'd10) r = 6'd10;
            else if (req <= 6'd15) r = 6'd15;
            else                   r = 6'd30;
            return r;
        end
    endfunction

endpackage

### sv/frd_ifs.sv
interface frd_frame_if import frd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] arrival_time;

    modport source (output valid, output arrival_time, input ready);
    modport sink   (input valid, input arrival_time, output ready);
endinterface

interface frd_cfg_if import frd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] requested_rate;

    modport source (output valid, output requested_rate, input ready);
    modport sink   (input valid, input requested_rate, output ready);
endinterface

interface frd_result_if import frd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              keep_frame;
    logic [TAG_W-1:0]  reported_rate;
    logic [MEAS_W-1:0] measured_rate;

    modport source (output valid, output keep_frame, output reported_rate,
                    output measured_rate, input ready);
    modport sink   (input valid, input keep_frame, input reported_rate,
                    input measured_rate, output ready);
endinterface

### sv/frame_rate_decimator_top.sv
// Frame rate decimator: one transfer on the frame channel per arriving frame,
// carrying its millisecond timestamp; one transfer on the result channel per
// frame, telling whether to keep it, the rate tag and the measured source rate.
// The cfg channel writes the requested rate (1..60 fps); the rate rule is
// re-evaluated on each write, which keeps the block busy until the rule is settled.
// An ordinary frame runs only the keep decision; a frame that closes a
// 4000 ms measuring window runs the measurement and the rule before it, the
// rule with its division only when needed. The measurement runs a 42-step
// division, the rule an 18-step division and the keep decision a 32-step
// remainder, all on one bit-per-cycle divider.
// The block takes no new frame before the last one is done; frame.ready is low
// while the sequencer works and cfg wins over a frame offered in idle.
// Reset clears the window, the tier (30), the skip count (1), the frame index
// and all valid flags; the result register comes up empty.
// When the receiver stalls, the pending result is held in the output register;
// the next frame may still be taken and computed, and its result waits inside
// the block until the output register drains.
module frame_rate_decimator_top import frd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    frd_frame_if.sink     frame,
    frd_cfg_if.sink       cfg,
    frd_result_if.source  result
);

    logic              idle;
    logic              frame_fire;
    logic              cfg_fire;
    logic              res_valid;
    logic              res_hold;
    frd_result_t       res_data;
    frd_div_req_t      div_req;
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_DW-1:0] div_divisor;
    logic              div_done;
    logic [DIV_NW-1:0] div_quot;
    logic [DIV_DW-1:0] div_rem;

    logic              out_valid_reg, out_valid_next;
    frd_result_t       out_data_reg, out_data_next;

    // cfg transfers take priority; frames wait while a write is offered
    assign cfg.ready   = idle;
    assign frame.ready = idle && !cfg.valid;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign frame_fire  = frame.valid && frame.ready;

    // hold the finished result inside while the output register is stalled
    assign res_hold = out_valid_reg && !result.ready;

    frd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_fire   (frame_fire),
        .arrival_time (frame.arrival_time),
        .cfg_fire     (cfg_fire),
        .cfg_data     (cfg.requested_rate),
        .idle         (idle),
        .res_valid    (res_valid),
        .res_hold     (res_hold),
        .res_data     (res_data),
        .div_req      (div_req),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .div_rem      (div_rem)
    );

    frd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // output register: load a new result, drop the old one once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.keep_frame    = out_data_reg.keep_frame;
    assign result.reported_rate = out_data_reg.reported_rate;
    assign result.measured_rate = out_data_reg.measured_rate;

endmodule

### sv/frd_div.sv
module frd_div import frd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  frd_div_req_t       req,
    input  logic [DIV_NW-1:0]  dividend,
    input  logic [DIV_DW-1:0]  divisor,
    output logic               done,
    output logic [DIV_NW-1:0]  quotient,
    output logic [DIV_DW-1:0]  remainder
);

    logic [DIV_NW-1:0] dq_reg, dq_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;

    // one restoring step per cycle; the dividend arrives left-aligned
    assign trial = {rem_reg, dq_reg[DIV_NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (req.start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = req.steps;
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            dq_next  = {dq_reg[DIV_NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

### sv/frd_ctrl.sv
module frd_ctrl import frd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_fire,
    input  logic [TS_W-1:0]   arrival_time,
    input  logic              cfg_fire,
    input  logic [RATE_W-1:0] cfg_data,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_hold,
    output frd_result_t       res_data,
    output frd_div_req_t      div_req,
    output logic [DIV_NW-1:0] div_dividend,
    output logic [DIV_DW-1:0] div_divisor,
    input  logic              div_done,
    input  logic [DIV_NW-1:0] div_quot,
    input  logic [DIV_DW-1:0] div_rem
);

    frd_state_t        state_reg, state_next;
    logic [TS_W-1:0]   win_start_reg, win_start_next;
    logic [TS_W-1:0]   frames_reg, frames_next;
    logic [MEAS_W-1:0] source_reg, source_next;
    logic [ADJ_W-1:0]  adjust_reg, adjust_next;
    logic [RATE_W-1:0] tier_reg, tier_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [TS_W-1:0]   index_reg, index_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              from_step_reg, from_step_next;
    logic [TS_W-1:0]   now_reg, now_next;
    logic [RATE_W-1:0] rule_req_reg, rule_req_next;

    logic [TS_W-1:0]   duration;
    logic [DIV_NW-1:0] product;
    logic [RATE_W-1:0] rule_den;
    logic [RATE_W-1:0] rule_tier;
    logic [17:0]       rule_num;
    logic [SKIP_W-1:0] rule_quot;

    assign duration  = now_reg - win_start_reg;
    assign product   = DIV_NW'(frames_reg) * DIV_NW'(MS_PER_S);
    assign rule_den  = (rule_req_reg == '0) ? RATE_W'(1) : rule_req_reg;
    assign rule_tier = rate_tier(rule_req_reg);
    assign rule_num  = {1'b0, source_reg, 1'b0} + 18'(rule_den);
    assign rule_quot = div_quot[SKIP_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        win_start_next = win_start_reg;
        frames_next    = frames_reg;
        source_next    = source_reg;
        adjust_next    = adjust_reg;
        tier_next      = tier_reg;
        skip_next      = skip_reg;
        index_next     = index_reg;
        tag_next       = tag_reg;
        from_step_next = from_step_reg;
        now_next       = now_reg;
        rule_req_next  = rule_req_reg;
        div_req.start  = 1'b0;
        div_req.steps  = MOD_STEPS;
        div_dividend   = {index_reg, {(DIV_NW-TS_W){1'b0}}};
        div_divisor    = DIV_DW'(skip_reg);
        res_valid      = 1'b0;
        res_data.keep_frame    = (div_rem == '0);
        res_data.reported_rate = tag_reg;
        res_data.measured_rate = source_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    rule_req_next  = cfg_data;
                    from_step_next = 1'b0;
                    state_next     = ST_RULE;
                end
                else if (frame_fire)
                begin
                    now_next    = arrival_time;
                    frames_next = frames_reg + 1'b1;
                    if (win_start_reg == '0)
                    begin
                        win_start_next = arrival_time;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (duration >= WINDOW_MS && adjust_reg < MAX_ADJUSTS)
                begin
                    div_req.start  = 1'b1;
                    div_req.steps  = MEAS_STEPS;
                    div_dividend   = product;
                    div_divisor    = duration;
                    frames_next    = '0;
                    win_start_next = now_reg;
                    adjust_next    = adjust_reg + 1'b1;
                    state_next     = ST_MEAS_DIV;
                end
                else
                begin
                    state_next = ST_MOD_LOAD;
                end
            end
            ST_MEAS_DIV:
            begin
                if (div_done)
                begin
                    source_next    = div_quot[MEAS_W-1:0];
                    rule_req_next  = tier_reg;
                    from_step_next = 1'b1;
                    state_next     = ST_RULE;
                end
            end
            ST_RULE:
            begin
                tier_next = rule_tier;
                if (MEAS_W'(rule_tier) >= source_reg)
                begin
                    skip_next  = SKIP_W'(1);
                    tag_next   = rate_ladder(source_reg);
                    state_next = from_step_reg ? ST_MOD_LOAD : ST_IDLE;
                end
                else
                begin
                    tag_next      = rule_tier[TAG_W-1:0];
                    div_req.start = 1'b1;
                    div_req.steps = RULE_STEPS;
                    div_dividend  = {rule_num, {(DIV_NW-18){1'b0}}};
                    div_divisor   = DIV_DW'({rule_den, 1'b0});
                    state_next    = ST_RULE_DIV;
                end
            end
            ST_RULE_DIV:
            begin
                if (div_done)
                begin
                    // a skip that truncates to zero saturates to one
                    skip_next  = (rule_quot == '0) ? SKIP_W'(1) : rule_quot;
                    state_next = from_step_reg ? ST_MOD_LOAD : ST_IDLE;
                end
            end
            ST_MOD_LOAD:
            begin
                div_req.start = 1'b1;
                state_next    = ST_MOD_DIV;
            end
            ST_MOD_DIV:
            begin
                if (div_done && !res_hold)
                begin
                    res_valid  = 1'b1;
                    index_next = index_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_start_reg <= '0;
            frames_reg    <= '0;
            source_reg    <= RESET_SRC;
            adjust_reg    <= '0;
            tier_reg      <= RESET_TIER;
            skip_reg      <= SKIP_W'(1);
            index_reg     <= '0;
            tag_reg       <= RESET_TAG;
            from_step_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_start_reg <= win_start_next;
            frames_reg    <= frames_next;
            source_reg    <= source_next;
            adjust_reg    <= adjust_next;
            tier_reg      <= tier_next;
            skip_reg      <= skip_next;
            index_reg     <= index_next;
            tag_reg       <= tag_next;
            from_step_reg <= from_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        rule_req_reg <= rule_req_next;
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

### sv/frd_chk.sv
`include "frame_rate_decimator_top_macros.svh"

module frd_chk import frd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    input  logic             frame_ready,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             result_valid,
    input  logic             result_ready,
    input  logic [TAG_W-1:0] reported_rate
);

    logic frame_xfer;
    logic cfg_xfer;
    logic result_stall;
    logic any_ready;
    logic tag_ok;

    assign frame_xfer   = frame_valid && frame_ready;
    assign cfg_xfer     = cfg_valid && cfg_ready;
    assign result_stall = result_valid && !result_ready;
    assign any_ready    = frame_ready || cfg_ready;
    assign tag_ok       = (reported_rate == 5'd1)  || (reported_rate == 5'd5)  ||
                          (reported_rate == 5'd10) || (reported_rate == 5'd15) ||
                          (reported_rate == 5'd20) || (reported_rate == 5'd25) ||
                          (reported_rate == 5'd30);

    `FRD_ASSERT(a_result_hold, result_stall |=> result_valid, "result dropped while stalled")

    `FRD_ASSERT(a_tag_legal, result_valid |-> tag_ok, "illegal rate tag")

    `FRD_ASSERT(a_busy_after_frame, frame_xfer |=> !any_ready, "ready while a frame is in work")

    `FRD_ASSERT(a_busy_after_cfg, cfg_xfer |=> !frame_ready, "frame taken during rate update")

    `FRD_ASSERT_ALWAYS(a_single_transfer, frame_xfer |-> !cfg_xfer, "frame and cfg together")

endmodule

bind frame_rate_decimator_top frd_chk u_frd_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_valid   (frame.valid),
    .frame_ready   (frame.ready),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .reported_rate (result.reported_rate)
);

### bench/frd_rate_checker.sv
`timescale 1ns / 100ps

// Watch the frame, cfg and result channels, keep a private copy of the
// decimator state and compare every result transfer with the oldest prediction.
module frd_rate_checker import frd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    frd_frame_if   frame,
    frd_cfg_if     cfg,
    frd_result_if  result,
    output int     fail_count,
    output int     outstanding
);

    localparam logic [TS_W-1:0] WINDOW_LEN_MS = 32'd4000;
    localparam logic [1:0]      ADJUST_LIMIT  = 2'd2;

    logic [RATE_W-1:0] req_rate;
    logic [TS_W-1:0]   win_start;
    logic [31:0]       win_frames;
    logic [MEAS_W-1:0] src_rate;
    logic [1:0]        adjusts_done;
    logic [RATE_W-1:0] tier;
    logic [SKIP_W-1:0] keep_every;
    logic [31:0]       frame_index;
    logic [TAG_W-1:0]  rate_tag;

    frd_result_t verdicts_due[$];
    int          mismatches = 0;
    int          results_seen = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // Tag for a source that is no faster than the tier: the next step at or above it.
    function automatic logic [TAG_W-1:0] tag_for(input logic [MEAS_W-1:0] total);
        logic [TAG_W-1:0] t;
        t = 5'd1;
        if (total > 16'd1)  t = 5'd5;
        if (total > 16'd5)  t = 5'd10;
        if (total > 16'd10) t = 5'd15;
        if (total > 16'd15) t = 5'd20;
        if (total > 16'd20) t = 5'd25;
        if (total > 16'd25) t = 5'd30;
        return t;
    endfunction

    // Pick the tier for a request and derive the keep-one-in-N count and the tag.
    function automatic void retune(input logic [RATE_W-1:0] req,
                                   input logic [MEAS_W-1:0] total);
        int unsigned divisor;
        int unsigned quot;
        if (req <= 6'd1)       tier = 6'd1;
        else if (req <= 6'd5)  tier = 6'd5;
        else if (req <= 6'd10) tier = 6'd10;
        else if (req <= 6'd15) tier = 6'd15;
        else                   tier = 6'd30;
        if (16'(tier) >= total) begin
            keep_every = 16'd1;
            rate_tag   = tag_for(total);
        end
        else begin
            divisor = (req == '0) ? 1 : 32'(req);
            quot    = (32'(total) * 2 + divisor) / (divisor * 2);
            if (quot == 0) quot = 1;
            keep_every = quot[15:0];
            if (keep_every == '0) keep_every = 16'd1;
            rate_tag = 5'(tier);
        end
    endfunction

    function automatic frd_result_t predict_frame(input logic [TS_W-1:0] stamp);
        logic [TS_W-1:0] span;
        logic [63:0]     rate_full;
        frd_result_t     r;
        if (win_start == '0) win_start = stamp;
        win_frames = win_frames + 32'd1;
        span = stamp - win_start;
        if (span >= WINDOW_LEN_MS && adjusts_done < ADJUST_LIMIT) begin
            rate_full    = (64'(win_frames) * 64'd1000) / 64'(span);
            src_rate     = rate_full[15:0];
            win_frames   = '0;
            win_start    = stamp;
            retune(tier, src_rate);
            adjusts_done = adjusts_done + 2'd1;
        end
        r.keep_frame    = (frame_index % 32'(keep_every)) == 0;
        frame_index     = frame_index + 32'd1;
        r.reported_rate = rate_tag;
        r.measured_rate = src_rate;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        frd_result_t due;
        if (!rst_n) begin
            req_rate     = RESET_REQ;
            win_start    = '0;
            win_frames   = '0;
            src_rate     = RESET_SRC;
            adjusts_done = '0;
            tier         = RESET_TIER;
            keep_every   = 16'd1;
            frame_index  = '0;
            rate_tag     = RESET_TAG;
            verdicts_due.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                req_rate = cfg.requested_rate;
                retune(req_rate, src_rate);
            end
            // retire the oldest prediction before queuing a new one
            if (result.valid && result.ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no frame pending",
                                              results_seen));
                end
                else begin
                    due = verdicts_due.pop_front();
                    if (result.keep_frame !== due.keep_frame)
                        report_mismatch($sformatf("result %0d: keep_frame %0b, expected %0b",
                                                  results_seen, result.keep_frame,
                                                  due.keep_frame));
                    if (result.reported_rate !== due.reported_rate)
                        report_mismatch($sformatf("result %0d: reported_rate %0d, expected %0d",
                                                  results_seen, result.reported_rate,
                                                  due.reported_rate));
                    if (result.measured_rate !== due.measured_rate)
                        report_mismatch($sformatf("result %0d: measured_rate %0d, expected %0d",
                                                  results_seen, result.measured_rate,
                                                  due.measured_rate));
                end
                results_seen++;
            end
            if (frame.valid && frame.ready)
                verdicts_due.push_back(predict_frame(frame.arrival_time));
            outstanding <= verdicts_due.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

// Top of the decimator bench: clock, reset, stimulus, handshake pacing and the
// final verdict. All prediction and comparison lives in the checker.
module tb import frd_pkg::*;
();

    localparam int              RX_HOLD_CYCLES = 600;
    localparam int              QUIET_LIMIT    = 5000;
    localparam int              DRAIN_CYCLES   = 200;
    localparam int              PHASE_FRAMES   = 100;
    localparam int              WARMUP_LAST    = 300;
    // frames 32 ms apart give a measured source rate of 31 fps
    localparam logic [TS_W-1:0] CADENCE_START  = 32'd3999;
    localparam logic [TS_W-1:0] CADENCE_MS     = 32'd32;
    // requested rates, one per random phase; the zero in slot six is
    // replaced by a random rate
    localparam logic [RATE_W-1:0] PHASE_RATE [8] =
        '{6'd0, 6'd63, 6'd1, 6'd60, 6'd10, 6'd15, 6'd0, 6'd30};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   tx_idle_pct  = 25;
    int   rx_idle_pct  = 75;
    bit   rx_hold      = 1'b0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   outstanding;

    frd_frame_if  frame_ch ();
    frd_cfg_if    cfg_ch ();
    frd_result_if result_ch ();

    frame_rate_decimator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    frd_rate_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame_ch),
        .cfg         (cfg_ch),
        .result      (result_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one frame; idle at random first, then hold valid until the transfer.
    // Valid stays high on return so back-to-back frames need no extra edge.
    task automatic send_frame(input logic [TS_W-1:0] stamp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.arrival_time <= stamp;
        do @(posedge clk); while (!frame_ch.ready);
    endtask

    // Write the requested rate only once every pending result has drained, so
    // the block is idle; every frame yields a result, so nothing else can be
    // in flight at that point.
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.requested_rate <= rate;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Receiver pacing: random back-pressure, plus one long hold on request
    // while the sender keeps offering, so the block fills and stalls its input.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((frame_ch.valid && frame_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [TS_W-1:0]   clock_ms;
        logic [RATE_W-1:0] rate;

        frame_ch.valid         = 1'b0;
        frame_ch.arrival_time  = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.requested_rate  = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Zero stamps leave the window unopened; the all-ones
        // stamp opens it and the next ones wrap through zero. The stamp at 3999
        // is the first with a 4000 ms span and closes the first window.
        send_frame('0);
        send_frame('0);
        send_frame('1);
        send_frame('0);
        send_frame(32'd1000);
        send_frame(32'd2000);
        send_frame(32'd3000);
        send_frame(32'd3998);
        send_frame(CADENCE_START);

        // Zero rate acts as the lowest tier: with a slow source it halves the stream.
        write_rate(6'd0);
        for (int k = 1; k <= 4; k++)
            send_frame(CADENCE_START + CADENCE_MS * k);
        // Top of the field: above the register's legal range.
        write_rate(6'd63);
        for (int k = 5; k <= 6; k++)
            send_frame(CADENCE_START + CADENCE_MS * k);
        // Leave a low tier in place so the second measurement decimates.
        write_rate(6'd5);

        // Warm-up: steady 32 ms cadence with small jitter, long enough to close
        // the second and last measuring window.
        for (int k = 7; k <= WARMUP_LAST; k++)
            send_frame(CADENCE_START + CADENCE_MS * k + $urandom_range(3));
        clock_ms = CADENCE_START + CADENCE_MS * (WARMUP_LAST + 1);

        // Random phases: one requested rate each. Most stamps advance a running
        // clock; the rest are full-width noise or zero.
        for (int p = 0; p < 8; p++)
        begin
            rate = (p == 6) ? RATE_W'($urandom_range(63)) : PHASE_RATE[p];
            write_rate(rate);
            if (p == 1)
            begin
                tx_idle_pct = 75;
                rx_idle_pct = 25;
            end
            if (p == 5)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                rx_hold     = 1'b1;
            end
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                case ($urandom_range(15))
                    0: send_frame($urandom);
                    1: send_frame('0);
                    default:
                    begin
                        clock_ms = clock_ms + $urandom_range(80, 1);
                        send_frame(clock_ms);
                    end
                endcase
            end
        end

        // Drop valid, wait for every prediction to be matched, then linger to
        // catch any stray result.
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
